@@ hdl/assert_macros.svh @@
// assertion macros used by quaternion_to_euler_angles
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked on every rising edge outside reset
`define Q2E_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// plain invariant checked on every rising edge outside reset
`define Q2E_ASSERT_ALWAYS(lbl, clk, rst, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

`endif

@@ hdl/q2e_pkg.sv @@
// shared constants for the quaternion to euler angle converter
// no dependencies
`default_nettype none

package q2e_pkg;

  localparam int COMPONENT_WIDTH     = 16;
  localparam int ANGLE_WIDTH         = 16;
  localparam int FUNCTION_ITERATIONS = 16;

  // angle accumulator, q30 radians plus headroom
  localparam int Z_WIDTH = 34;

  localparam longint PI_Q30      = 64'sd3373259426;
  localparam longint HALF_PI_Q30 = 64'sd1686629713;

  // atan(2^-i) in q30, truncated except the last four entries, which are rounded
  localparam logic [31:0] ATAN_Q30 [31] = '{
    32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76, 32'h01FFD55B,
    32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD, 32'h000FFFFF, 32'h0007FFFF,
    32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF, 32'h00007FFF, 32'h00003FFF, 32'h00001FFF,
    32'h00000FFF, 32'h000007FF, 32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F,
    32'h0000003F, 32'h0000001F, 32'h0000000F, 32'h00000008, 32'h00000004, 32'h00000002,
    32'h00000001
  };

  // fraction bits of the product sums
  function automatic int work_frac(input int cw);
    int raw;
    raw = 2 * (cw - 2);
    return (raw > 30) ? 30 : raw;
  endfunction

endpackage

`default_nettype wire

@@ hdl/q2e_sqrt_cell.sv @@
// one digit step of the restoring integer square root chain
// uses q2e_pkg only through the parent's parameters
`default_nettype none

module q2e_sqrt_cell #(
  parameter int WORK_FRAC     = 28,
  parameter int STEP          = 0,
  parameter int PAYLOAD_WIDTH = 1
) (
  input  wire logic                       clk,
  input  wire logic [2*WORK_FRAC+1:0]     n_in,
  input  wire logic [2*WORK_FRAC+1:0]     res_in,
  input  wire logic [PAYLOAD_WIDTH-1:0]   pay_in,
  output      logic [2*WORK_FRAC+1:0]     n_out,
  output      logic [2*WORK_FRAC+1:0]     res_out,
  output      logic [PAYLOAD_WIDTH-1:0]   pay_out
);

  localparam int NW = 2 * WORK_FRAC + 2;
  localparam logic [NW-1:0] BIT = NW'(1) << (2 * (WORK_FRAC - STEP));

  logic [NW-1:0] trial;
  logic [NW-1:0] n_next;
  logic [NW-1:0] res_next;

  always_comb begin
    trial = res_in + BIT;
    if (n_in >= trial) begin
      n_next   = n_in - trial;
      res_next = (res_in >> 1) + BIT;
    end else begin
      n_next   = n_in;
      res_next = res_in >> 1;
    end
  end

  always_ff @(posedge clk) begin
    n_out   <= n_next;
    res_out <= res_next;
    pay_out <= pay_in;
  end

endmodule

`default_nettype wire

@@ hdl/q2e_cordic_cell.sv @@
// one vectoring rotation step of the arctangent chain
// depends on q2e_pkg for the angle table
`default_nettype none

module q2e_cordic_cell #(
  parameter int DATA_WIDTH = 36,
  parameter int STEP       = 0
) (
  input  wire logic                                  clk,
  input  wire logic signed [DATA_WIDTH-1:0]          x_in,
  input  wire logic signed [DATA_WIDTH-1:0]          y_in,
  input  wire logic signed [q2e_pkg::Z_WIDTH-1:0]    z_in,
  input  wire logic                                  zero_in,
  output      logic signed [DATA_WIDTH-1:0]          x_out,
  output      logic signed [DATA_WIDTH-1:0]          y_out,
  output      logic signed [q2e_pkg::Z_WIDTH-1:0]    z_out,
  output      logic                                  zero_out
);

  localparam int ZW = q2e_pkg::Z_WIDTH;
  localparam logic signed [ZW-1:0] ANG = ZW'(q2e_pkg::ATAN_Q30[STEP]);

  logic signed [DATA_WIDTH-1:0] dx;
  logic signed [DATA_WIDTH-1:0] dy;
  logic signed [DATA_WIDTH-1:0] x_next;
  logic signed [DATA_WIDTH-1:0] y_next;
  logic signed [ZW-1:0]         z_next;

  always_comb begin
    dx = y_in >>> STEP;
    dy = x_in >>> STEP;
    if (y_in > 0) begin
      x_next = x_in + dx;
      y_next = y_in - dy;
      z_next = z_in + ANG;
    end else begin
      x_next = x_in - dx;
      y_next = y_in + dy;
      z_next = z_in - ANG;
    end
  end

  always_ff @(posedge clk) begin
    x_out    <= x_next;
    y_out    <= y_next;
    z_out    <= z_next;
    zero_out <= zero_in;
  end

endmodule

`default_nettype wire

@@ hdl/q2e_cordic.sv @@
// two-argument arctangent: half plane turn followed by a chain of rotation cells
// depends on q2e_pkg and q2e_cordic_cell
`default_nettype none

module q2e_cordic #(
  parameter int DATA_WIDTH = 36,
  parameter int ITERATIONS = q2e_pkg::FUNCTION_ITERATIONS
) (
  input  wire logic                                clk,
  input  wire logic signed [DATA_WIDTH-1:0]        x,
  input  wire logic signed [DATA_WIDTH-1:0]        y,
  output      logic signed [q2e_pkg::Z_WIDTH-1:0]  angle,
  output      logic                                zero
);

  localparam int ZW = q2e_pkg::Z_WIDTH;
  localparam logic signed [ZW-1:0] HALF = ZW'(q2e_pkg::HALF_PI_Q30);

  logic signed [DATA_WIDTH-1:0] xs   [ITERATIONS+1];
  logic signed [DATA_WIDTH-1:0] ys   [ITERATIONS+1];
  logic signed [ZW-1:0]         zs   [ITERATIONS+1];
  logic                         zf   [ITERATIONS+1];

  // left half plane is turned by a quarter into the right one
  always_ff @(posedge clk) begin
    zf[0] <= (x == '0) && (y == '0);
    if (x < 0) begin
      if (y >= 0) begin
        xs[0] <= y;
        ys[0] <= -x;
        zs[0] <= HALF;
      end else begin
        xs[0] <= -y;
        ys[0] <= x;
        zs[0] <= -HALF;
      end
    end else begin
      xs[0] <= x;
      ys[0] <= y;
      zs[0] <= '0;
    end
  end

  for (genvar i = 0; i < ITERATIONS; i++) begin : g_cell
    q2e_cordic_cell #(
      .DATA_WIDTH(DATA_WIDTH),
      .STEP      (i)
    ) u_cell (
      .clk     (clk),
      .x_in    (xs[i]),
      .y_in    (ys[i]),
      .z_in    (zs[i]),
      .zero_in (zf[i]),
      .x_out   (xs[i+1]),
      .y_out   (ys[i+1]),
      .z_out   (zs[i+1]),
      .zero_out(zf[i+1])
    );
  end

  assign angle = zs[ITERATIONS];
  assign zero  = zf[ITERATIONS];

endmodule

`default_nettype wire

@@ hdl/quaternion_to_euler_angles.sv @@
// quaternion to roll / pitch / yaw converter, fully pipelined
// depends on q2e_pkg, q2e_sqrt_cell, q2e_cordic, assert_macros.svh
//
//   channel  | handshake      | payload
//   ---------+----------------+---------------------------------------------
//   request  | start / busy   | quat_w, quat_x, quat_y, quat_z
//   result   | valid (strobe) | roll_angle, pitch_angle, yaw_angle, pitch_clamped
//
// one request is taken every clock; busy is never raised
// results pass through the square root digit chain and the arctangent rotation chain
// rst clears only the valid tracking line; payload registers are not reset
// results appear for one cycle on valid and cannot be held off
`default_nettype none
`include "assert_macros.svh"

module quaternion_to_euler_angles #(
  parameter int COMPONENT_WIDTH     = q2e_pkg::COMPONENT_WIDTH,
  parameter int ANGLE_WIDTH         = q2e_pkg::ANGLE_WIDTH,
  parameter int FUNCTION_ITERATIONS = q2e_pkg::FUNCTION_ITERATIONS
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               start,
  output      logic                               busy,
  input  wire logic signed [COMPONENT_WIDTH-1:0]  quat_w,
  input  wire logic signed [COMPONENT_WIDTH-1:0]  quat_x,
  input  wire logic signed [COMPONENT_WIDTH-1:0]  quat_y,
  input  wire logic signed [COMPONENT_WIDTH-1:0]  quat_z,
  output      logic                               valid,
  output      logic signed [ANGLE_WIDTH-1:0]      roll_angle,
  output      logic signed [ANGLE_WIDTH-2:0]      pitch_angle,
  output      logic signed [ANGLE_WIDTH-1:0]      yaw_angle,
  output      logic                               pitch_clamped
);

  localparam int CW  = COMPONENT_WIDTH;
  localparam int WF  = q2e_pkg::work_frac(COMPONENT_WIDTH);
  localparam int PS  = 2 * (CW - 2) - WF;
  localparam int DW  = WF + 8;
  localparam int NW  = 2 * WF + 2;
  localparam int ZW  = q2e_pkg::Z_WIDTH;
  localparam int OS  = 33 - ANGLE_WIDTH;
  localparam int PW  = 5 * DW + 1;
  localparam int FI  = FUNCTION_ITERATIONS;
  localparam int LAT = WF + FI + 8;

  localparam longint RND     = 64'sd1 <<< (OS - 1);
  localparam longint LIM_PI  = (q2e_pkg::PI_Q30 + RND) >>> OS;
  localparam longint LIM_HPI = (q2e_pkg::HALF_PI_Q30 + RND) >>> OS;

  localparam logic signed [DW-1:0] ONE = DW'(1) <<< WF;

  logic [LAT-1:0] vld;

  // stage 0: captured request
  logic signed [CW-1:0] w0, x0, y0, z0;
  // stage 1: products
  logic signed [DW-1:0] pwx, pyz, pxx, pyy, pwz, pxy, pzz, pwy, pzx;
  // stage 2: product sums
  logic signed [DW-1:0] sr2, cr2, sy2, cy2, sp2;
  // stage 3: square of the arcsine argument
  logic [2*WF-1:0]      sq3;
  logic [PW-1:0]        pay3;
  // stage 4: square root operand
  logic [NW-1:0]        n4;
  logic [PW-1:0]        pay4;

  logic signed [DW-1:0] mag2;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[LAT-2:0], start && !busy};
    end
  end

  function automatic logic signed [DW-1:0] prod(input logic signed [CW-1:0] a,
                                                input logic signed [CW-1:0] b);
    logic signed [2*CW-1:0] full;
    full = a * b;
    return DW'(full >>> PS);
  endfunction

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      w0 <= quat_w;
      x0 <= quat_x;
      y0 <= quat_y;
      z0 <= quat_z;
    end
    pwx <= prod(w0, x0);
    pyz <= prod(y0, z0);
    pxx <= prod(x0, x0);
    pyy <= prod(y0, y0);
    pwz <= prod(w0, z0);
    pxy <= prod(x0, y0);
    pzz <= prod(z0, z0);
    pwy <= prod(w0, y0);
    pzx <= prod(z0, x0);
    sr2 <= (pwx + pyz) <<< 1;
    cr2 <= ONE - ((pxx + pyy) <<< 1);
    sy2 <= (pwz + pxy) <<< 1;
    cy2 <= ONE - ((pyy + pzz) <<< 1);
    sp2 <= (pwy - pzx) <<< 1;
  end

  assign mag2 = sp2[DW-1] ? -sp2 : sp2;

  // square only matters when |s| < 1, so its low bits carry the whole magnitude
  always_ff @(posedge clk) begin
    sq3  <= mag2[WF-1:0] * mag2[WF-1:0];
    pay3 <= {sr2, cr2, sy2, cy2, sp2, (sp2 >= ONE) || (sp2 <= -ONE)};
    n4   <= (NW'(1) << (2 * WF)) - NW'(sq3);
    pay4 <= pay3;
  end

  logic [NW-1:0] sn   [WF+2];
  logic [NW-1:0] sres [WF+2];
  logic [PW-1:0] spay [WF+2];

  assign sn[0]   = n4;
  assign sres[0] = '0;
  assign spay[0] = pay4;

  for (genvar k = 0; k <= WF; k++) begin : g_sqrt
    q2e_sqrt_cell #(
      .WORK_FRAC    (WF),
      .STEP         (k),
      .PAYLOAD_WIDTH(PW)
    ) u_sqrt (
      .clk    (clk),
      .n_in   (sn[k]),
      .res_in (sres[k]),
      .pay_in (spay[k]),
      .n_out  (sn[k+1]),
      .res_out(sres[k+1]),
      .pay_out(spay[k+1])
    );
  end

  logic signed [DW-1:0] sr_s, cr_s, sy_s, cy_s, sp_s, cp_s;
  logic                 clamp_s;

  assign {sr_s, cr_s, sy_s, cy_s, sp_s, clamp_s} = spay[WF+1];
  assign cp_s = sres[WF+1][DW-1:0];

  logic signed [ZW-1:0] z_roll, z_yaw, z_pitch;
  logic                 zero_roll, zero_yaw, zero_pitch;

  q2e_cordic #(.DATA_WIDTH(DW), .ITERATIONS(FI)) u_roll (
    .clk(clk), .x(cr_s), .y(sr_s), .angle(z_roll), .zero(zero_roll)
  );

  q2e_cordic #(.DATA_WIDTH(DW), .ITERATIONS(FI)) u_yaw (
    .clk(clk), .x(cy_s), .y(sy_s), .angle(z_yaw), .zero(zero_yaw)
  );

  q2e_cordic #(.DATA_WIDTH(DW), .ITERATIONS(FI)) u_pitch (
    .clk(clk), .x(cp_s), .y(sp_s), .angle(z_pitch), .zero(zero_pitch)
  );

  // clamp flag and argument sign ride alongside the rotation chain
  logic [1:0] side [FI+1];

  always_ff @(posedge clk) begin
    side[0] <= {clamp_s, sp_s > 0};
    for (int i = 0; i < FI; i++) begin
      side[i+1] <= side[i];
    end
  end

  function automatic logic signed [ZW:0] to_out(input logic signed [ZW-1:0] z,
                                                input logic                 zero,
                                                input longint               lim);
    logic signed [ZW:0] v;
    logic signed [ZW:0] l;
    l = (ZW+1)'(lim);
    v = ((ZW+1)'(z) + (ZW+1)'(RND)) >>> OS;
    if (zero) begin
      v = '0;
    end
    if (v > l) begin
      v = l;
    end
    if (v < -l) begin
      v = -l;
    end
    return v;
  endfunction

  logic signed [ZW:0] roll_v, yaw_v, pitch_v;

  always_comb begin
    roll_v = to_out(z_roll, zero_roll, LIM_PI);
    yaw_v  = to_out(z_yaw, zero_yaw, LIM_PI);
    if (side[FI][1]) begin
      pitch_v = side[FI][0] ? (ZW+1)'(LIM_HPI) : -(ZW+1)'(LIM_HPI);
    end else begin
      pitch_v = to_out(z_pitch, zero_pitch, LIM_HPI);
    end
  end

  always_ff @(posedge clk) begin
    roll_angle    <= ANGLE_WIDTH'(roll_v);
    yaw_angle     <= ANGLE_WIDTH'(yaw_v);
    pitch_angle   <= (ANGLE_WIDTH-1)'(pitch_v);
    pitch_clamped <= side[FI][1];
  end

  assign valid = vld[LAT-1];

  localparam logic signed [ANGLE_WIDTH-2:0] HPI_OUT = (ANGLE_WIDTH-1)'(LIM_HPI);

  `Q2E_ASSERT_IMPL(a_result_has_request, clk, rst, valid, $past(start, LAT), "result without request")
  `Q2E_ASSERT_IMPL(a_clamp_value, clk, rst, valid && pitch_clamped, (pitch_angle == HPI_OUT) || (pitch_angle == -HPI_OUT), "clamped pitch not at quarter turn")
  `Q2E_ASSERT_ALWAYS(a_never_busy, clk, rst, !busy, "busy raised")

endmodule

`default_nettype wire
